### hw/rtl/pfts_pkg.sv
// Package for the priority FIFO task scheduler: sizes, codes, command and
// status structs shared by the controller and the datapath. No dependencies.
package pfts_pkg;

	localparam int NumTasks   = 16;
	localparam int PrioLevels = 8;
	localparam int NumQueues  = PrioLevels + 3;
	localparam int TaskW  = $clog2(NumTasks);
	localparam int LinkW  = TaskW + 1;
	localparam int PrioW  = (PrioLevels > 1) ? $clog2(PrioLevels) : 1;
	localparam int QueueW = $clog2(NumQueues + 1);

	localparam logic [QueueW-1:0] QBlocked = QueueW'(PrioLevels);
	localparam logic [QueueW-1:0] QSuspend = QueueW'(PrioLevels + 1);
	localparam logic [QueueW-1:0] QDestroy = QueueW'(PrioLevels + 2);
	localparam logic [QueueW-1:0] QNone    = QueueW'(NumQueues);
	localparam logic [LinkW-1:0]  LinkNone = LinkW'(NumTasks);

	typedef enum logic [2:0] {
		ACT_READY    = 3'd0,
		ACT_SUSPEND  = 3'd1,
		ACT_BLOCK    = 3'd2,
		ACT_DESTROY  = 3'd3,
		ACT_SIGNAL   = 3'd4,
		ACT_DISPATCH = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		KIND_ACK      = 2'd0,
		KIND_DISPATCH = 2'd1,
		KIND_FREED    = 2'd2,
		KIND_IDLE     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNLINK,
		ST_APPEND,
		ST_FREE,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic              load;       // capture input item
		logic              unlink;     // unlink the working task
		logic              append;     // append working task to target queue
		logic              sel_head;   // working task := head of selected queue
		logic              clr_prio;   // reset priority of working task
		logic              set_prio;   // record priority of working task
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic              task_ok;     // task id in range
		logic              in_blocked;  // input task sits in blocked queue
		logic              ready_any;   // some ready queue non-empty
		logic              destroy_any; // destroy queue non-empty
		logic              destroy_last;// destroy head is its tail
	} dp_stat_t;

endpackage

### hw/rtl/priority_fifo_task_scheduler.sv
// Top level of the fixed-priority FIFO task scheduler.
// Channel  Dir  tdata (low bit up)                tuser
// s_axis   in   task_id[3:0], priority_req[6:4]   action[2:0]
// m_axis   out  result_task[3:0]                  kind[1:0]; tlast = last
// Steps up to the output register: a moving action goes through accept,
// unlink and append; one that moves nothing, through accept; a dispatch of
// a ready task, accept, head select, unlink, append; an idle one, accept,
// head select; a freeing one, accept, then select and output per freed task.
// Reset empties every queue and clears all priorities at once.
// A stalled output holds the sequencer before the next result and the input.
module priority_fifo_task_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // task_id, priority_req
	input  logic [2:0]  s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // result_task
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast
);
	import pfts_pkg::*;

	dp_cmd_t  cmd_c, cmd;
	dp_stat_t stat;
	logic       use_task;
	logic [3:0] cur_task;
	logic [3:0] task_q;

	pfts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_action(s_axis_tuser),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_kind(m_axis_tuser), .out_last(m_axis_tlast), .out_use_task(use_task),
		.cmd(cmd_c), .stat(stat)
	);

	pfts_top_glue u_glue (
		.take(s_axis_tvalid && s_axis_tready), .in_action(s_axis_tuser),
		.task_ok(stat.task_ok), .cmd_in(cmd_c), .cmd_out(cmd),
		.clk(clk), .arst_n(arst_n)
	);

	pfts_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_action(s_axis_tuser), .in_task(s_axis_tdata[3:0]),
		.in_prio(s_axis_tdata[6:4]), .stat(stat), .cur_task(cur_task)
	);

	// hold result task with the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			task_q <= '0;
		else if (!m_axis_tvalid || m_axis_tready)
			task_q <= use_task ? cur_task : 4'd0;
	end

	assign m_axis_tdata = {4'b0000, task_q};

endmodule

### hw/rtl/pfts_datapath.sv
// Datapath of the task scheduler: task tables, queue heads/tails and link
// registers, plus unlink/append operations. Depends on pfts_pkg.
module pfts_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfts_pkg::dp_cmd_t      cmd,
	input  logic [2:0]             in_action,
	input  logic [3:0]             in_task,
	input  logic [2:0]             in_prio,
	output pfts_pkg::dp_stat_t     stat,
	output logic [3:0]             cur_task
);
	import pfts_pkg::*;

	logic [QueueW-1:0] task_queue_q [NumTasks];
	logic [PrioW-1:0]  task_prio_q  [NumTasks];
	logic [LinkW-1:0]  next_q [NumTasks];
	logic [LinkW-1:0]  prev_q [NumTasks];
	logic [LinkW-1:0]  head_q [NumQueues];
	logic [LinkW-1:0]  tail_q [NumQueues];

	logic [TaskW-1:0]  task_q;
	logic [QueueW-1:0] target_q;
	logic [PrioW-1:0]  prio_q;

	logic [PrioW-1:0]  prio_sat;
	logic [QueueW-1:0] tgt_sel;
	logic [QueueW-1:0] ready_lv;
	logic              ready_hit;
	logic [QueueW-1:0] cq;
	logic [LinkW-1:0]  up, un;
	logic [QueueW-1:0] head_qsel;
	logic [LinkW-1:0]  sel_h;

	always_comb begin
		if ({29'd0, in_prio} >= PrioLevels)
			prio_sat = PrioW'(PrioLevels - 1);
		else
			prio_sat = PrioW'(in_prio);
	end

	always_comb begin
		ready_hit = 1'b0;
		ready_lv  = '0;
		for (int i = PrioLevels - 1; i >= 0; i--) begin
			if (!head_q[i][LinkW-1]) begin
				ready_hit = 1'b1;
				ready_lv  = QueueW'(i);
			end
		end
	end

	always_comb begin
		unique case (action_t'(in_action))
			ACT_READY:   tgt_sel = QueueW'(prio_sat);
			ACT_SUSPEND: tgt_sel = QSuspend;
			ACT_DESTROY: tgt_sel = QDestroy;
			ACT_SIGNAL:  tgt_sel = QueueW'(task_prio_q[in_task[TaskW-1:0]]);
			default:     tgt_sel = QBlocked;
		endcase
	end

	assign head_qsel = ready_hit ? ready_lv : QDestroy;
	assign sel_h     = head_q[head_qsel];
	assign cq        = task_queue_q[task_q];
	assign up        = prev_q[task_q];
	assign un        = next_q[task_q];

	assign stat.task_ok      = ({1'b0, in_task} < 5'(NumTasks));
	assign stat.in_blocked   = (task_queue_q[in_task[TaskW-1:0]] == QBlocked);
	assign stat.ready_any    = ready_hit;
	assign stat.destroy_any  = !head_q[QDestroy][LinkW-1];
	assign stat.destroy_last = (head_q[QDestroy] == tail_q[QDestroy]);
	assign cur_task          = 4'(task_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumTasks; i++) begin
				task_queue_q[i] <= QNone;
				task_prio_q[i]  <= '0;
			end
			for (int i = 0; i < NumQueues; i++) begin
				head_q[i] <= LinkNone;
				tail_q[i] <= LinkNone;
			end
			task_q   <= '0;
			target_q <= '0;
			prio_q   <= '0;
		end else begin
			if (cmd.load) begin
				task_q   <= in_task[TaskW-1:0];
				target_q <= tgt_sel;
				prio_q   <= prio_sat;
			end
			if (cmd.sel_head) begin
				task_q   <= sel_h[TaskW-1:0];
				target_q <= QBlocked;
			end
			if (cmd.set_prio)
				task_prio_q[task_q] <= prio_q;
			if (cmd.clr_prio)
				task_prio_q[task_q] <= '0;
			if (cmd.unlink && cq != QNone) begin
				if (up[LinkW-1])
					head_q[cq] <= un;
				if (un[LinkW-1])
					tail_q[cq] <= up;
				task_queue_q[task_q] <= QNone;
			end
			if (cmd.append) begin
				if (tail_q[target_q][LinkW-1])
					head_q[target_q] <= LinkW'(task_q);
				tail_q[target_q]     <= LinkW'(task_q);
				task_queue_q[task_q] <= target_q;
			end
		end
	end

	// links are only read for tasks that sit in a queue, so they need no reset
	always_ff @(posedge clk) begin
		if (cmd.unlink && cq != QNone) begin
			if (!up[LinkW-1])
				next_q[up[TaskW-1:0]] <= un;
			if (!un[LinkW-1])
				prev_q[un[TaskW-1:0]] <= up;
		end
		if (cmd.append) begin
			prev_q[task_q] <= tail_q[target_q];
			next_q[task_q] <= LinkNone;
			if (!tail_q[target_q][LinkW-1])
				next_q[tail_q[target_q][TaskW-1:0]] <= LinkW'(task_q);
		end
	end

endmodule

### hw/rtl/pfts_ctrl.sv
// Controller of the task scheduler: sequences unlink/append steps and the
// output register. Depends on pfts_pkg.
module pfts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          in_action,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_kind,
	output logic                out_last,
	output logic                out_use_task,
	output pfts_pkg::dp_cmd_t   cmd,
	input  pfts_pkg::dp_stat_t  stat
);
	import pfts_pkg::*;

	state_t state_q, state_d;
	logic   valid_q, valid_d;
	kind_t  kind_q, kind_d;
	logic   last_q, last_d, use_q, use_d;
	logic   take;
	logic   do_move;

	assign out_valid    = valid_q;
	assign out_kind     = kind_q;
	assign out_last     = last_q;
	assign out_use_task = use_q;
	assign in_ready     = (state_q == ST_IDLE) && (!valid_q || out_ready);
	assign take         = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			kind_q  <= KIND_ACK;
			last_q  <= 1'b0;
			use_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			kind_q  <= kind_d;
			last_q  <= last_d;
			use_q   <= use_d;
		end
	end

	always_comb begin
		state_d = state_q;
		valid_d = valid_q && !out_ready;
		kind_d  = kind_q;
		last_d  = last_q;
		use_d   = use_q;
		cmd     = '0;
		do_move = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.load = 1'b1;
					if (in_action == ACT_DISPATCH) begin
						state_d = ST_FREE;
					end else if (stat.task_ok && in_action <= ACT_SIGNAL &&
						(in_action != ACT_SIGNAL || stat.in_blocked)) begin
						do_move = 1'b1;
						state_d = ST_UNLINK;
					end else begin
						state_d = ST_OUT;
					end
					kind_d = KIND_ACK;
					last_d = 1'b1;
					use_d  = 1'b0;
					if (do_move && in_action == ACT_READY)
						state_d = ST_UNLINK;
				end
			end
			ST_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d    = ST_APPEND;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_OUT;
				if (kind_q == KIND_ACK)
					cmd.set_prio = 1'b0;
			end
			ST_FREE: begin
				// one destroyed task per pass; wait for room in the output
				if (!valid_q || out_ready) begin
					if (stat.ready_any) begin
						cmd.sel_head = 1'b1;
						kind_d  = KIND_DISPATCH;
						use_d   = 1'b1;
						last_d  = 1'b1;
						state_d = ST_UNLINK;
					end else if (stat.destroy_any) begin
						cmd.sel_head = 1'b1;
						kind_d  = KIND_FREED;
						use_d   = 1'b1;
						last_d  = stat.destroy_last;
						state_d = ST_OUT;
					end else begin
						kind_d  = KIND_IDLE;
						use_d   = 1'b0;
						last_d  = 1'b1;
						state_d = ST_OUT;
					end
				end
			end
			ST_OUT: begin
				if (kind_q == KIND_FREED) begin
					cmd.unlink   = 1'b1;
					cmd.clr_prio = 1'b1;
				end
				valid_d = 1'b1;
				state_d = (kind_q == KIND_FREED && !last_q) ? ST_FREE : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hw/rtl/pfts_top_glue.sv
// Ready-action priority capture: records the priority on the ready action.
// Depends on pfts_pkg.
module pfts_top_glue (
	input  logic               take,
	input  logic [2:0]         in_action,
	input  logic               task_ok,
	input  pfts_pkg::dp_cmd_t  cmd_in,
	output pfts_pkg::dp_cmd_t  cmd_out,
	input  logic               clk,
	input  logic               arst_n
);
	import pfts_pkg::*;

	logic pend_q;

	// set priority together with the unlink step of a ready action
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 1'b0;
		else if (take)
			pend_q <= (in_action == ACT_READY) && task_ok;
		else if (cmd_in.unlink)
			pend_q <= 1'b0;
	end

	always_comb begin
		cmd_out          = cmd_in;
		cmd_out.set_prio = pend_q && cmd_in.unlink;
	end

endmodule

### bench/pfts_checker.sv
// Checker for the priority FIFO task scheduler: watches both stream channels,
// runs a behavioral scheduler on each input transfer and compares results.
// Depends on pfts_pkg.
`timescale 1ns / 1ps

module pfts_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // task_id, priority_req
	input  logic [2:0]  s_axis_tuser,   // action
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // result_task
	input  logic [1:0]  m_axis_tuser,   // kind
	input  logic        m_axis_tlast,
	output int          errors,
	output int          pending,
	output int          n_results,
	output int          n_freed,
	output int          n_dispatched
);
	import pfts_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] task_no;
		logic       last;
	} sched_result_t;

	sched_result_t sched_results_q[$];

	int unsigned task_queue[NumTasks];
	int unsigned task_prio[NumTasks];
	int unsigned next_link[NumTasks];
	int unsigned prev_link[NumTasks];
	int unsigned queue_head[NumQueues];
	int unsigned queue_tail[NumQueues];

	function automatic void model_reset();
		for (int i = 0; i < NumTasks; i++) begin
			task_queue[i] = NumQueues;
			task_prio[i] = 0;
			next_link[i] = 0;
			prev_link[i] = 0;
		end
		for (int i = 0; i < NumQueues; i++) begin
			queue_head[i] = NumTasks;
			queue_tail[i] = NumTasks;
		end
	endfunction

	function automatic void unlink_task(int unsigned t);
		int unsigned q;
		int unsigned p;
		int unsigned n;
		q = task_queue[t];
		if (q >= NumQueues) return;
		p = prev_link[t];
		n = next_link[t];
		if (p >= NumTasks) queue_head[q] = n;
		else next_link[p] = n;
		if (n >= NumTasks) queue_tail[q] = p;
		else prev_link[n] = p;
		task_queue[t] = NumQueues;
	endfunction

	function automatic void append_task(int unsigned t, int unsigned q);
		int unsigned tl;
		tl = queue_tail[q];
		prev_link[t] = tl;
		next_link[t] = NumTasks;
		if (tl >= NumTasks) queue_head[q] = t;
		else next_link[tl] = t;
		queue_tail[q] = t;
		task_queue[t] = q;
	endfunction

	function automatic void push_result(kind_t k, int unsigned t, logic l);
		sched_result_t r;
		r.kind = k;
		r.task_no = 4'(t);
		r.last = l;
		sched_results_q.push_back(r);
	endfunction

	function automatic void schedule_step(logic [2:0] act, int unsigned t, int unsigned pr);
		int unsigned h;
		int n;
		n = 0;
		if (act == ACT_DISPATCH) begin
			for (int lv = 0; lv < PrioLevels; lv++) begin
				h = queue_head[lv];
				if (h < NumTasks) begin
					unlink_task(h);
					append_task(h, QBlocked);
					push_result(KIND_DISPATCH, h, 1'b1);
					return;
				end
			end
			while (queue_head[QDestroy] < NumTasks) begin
				h = queue_head[QDestroy];
				unlink_task(h);
				task_prio[h] = 0;
				push_result(KIND_FREED, h, queue_head[QDestroy] >= NumTasks);
				n++;
			end
			if (n == 0) push_result(KIND_IDLE, 0, 1'b1);
			return;
		end
		if (act <= ACT_SIGNAL && t < NumTasks) begin
			case (act)
				ACT_READY: begin
					if (pr >= PrioLevels) pr = PrioLevels - 1;
					task_prio[t] = pr;
					unlink_task(t);
					append_task(t, pr);
				end
				ACT_SUSPEND: begin
					unlink_task(t);
					append_task(t, QSuspend);
				end
				ACT_BLOCK: begin
					unlink_task(t);
					append_task(t, QBlocked);
				end
				ACT_DESTROY: begin
					unlink_task(t);
					append_task(t, QDestroy);
				end
				default: begin
					if (task_queue[t] == QBlocked) begin
						unlink_task(t);
						append_task(t, task_prio[t]);
					end
				end
			endcase
		end
		push_result(KIND_ACK, 0, 1'b1);
	endfunction

	always @(posedge clk) begin
		sched_result_t want;
		if (!arst_n) begin
			model_reset();
			sched_results_q.delete();
			errors = 0;
			n_results = 0;
			n_freed = 0;
			n_dispatched = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				schedule_step(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[6:4]);
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (sched_results_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: got kind %0d task %0d last %0b", $time,
						m_axis_tuser, m_axis_tdata[3:0], m_axis_tlast);
				end else begin
					want = sched_results_q.pop_front();
					if (want.kind == KIND_FREED) n_freed++;
					if (want.kind == KIND_DISPATCH) n_dispatched++;
					if (m_axis_tuser !== want.kind || m_axis_tdata[3:0] !== want.task_no ||
							m_axis_tlast !== want.last || m_axis_tdata[7:4] !== 4'b0000) begin
						errors++;
						$display("%0t: mismatch: expected kind %0d task %0d last %0b, got kind %0d tdata %h last %0b",
							$time, want.kind, want.task_no, want.last, m_axis_tuser,
							m_axis_tdata, m_axis_tlast);
					end
				end
			end
		end
		pending = sched_results_q.size();
	end

endmodule

### bench/priority_fifo_task_scheduler_tb.sv
// Testbench top for the priority FIFO task scheduler: drives task actions
// with random gaps and back-pressure, gives the verdict from pfts_checker.
// Depends on pfts_pkg, pfts_checker and the scheduler RTL.
`timescale 1ns / 1ps

module priority_fifo_task_scheduler_tb;
	import pfts_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // task_id, priority_req
	logic [2:0]  s_axis_tuser;   // action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // result_task
	logic [1:0]  m_axis_tuser;   // kind
	logic        m_axis_tlast;

	int errors, pending, n_results, n_freed, n_dispatched;
	int quiet_cycles;
	bit stall_go;
	bit stall_taken;

	priority_fifo_task_scheduler u_dut (.*);

	pfts_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// keep tvalid high across a zero gap so transfers go back to back
	task automatic send_action(logic [2:0] act, logic [3:0] t, logic [2:0] pr);
		int gap;
		s_axis_tuser <= act;
		s_axis_tdata <= {1'b0, pr, t};
		s_axis_tvalid <= 1'b1;
		@(posedge clk iff s_axis_tready);
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Mostly ready/block/signal traffic so queues fill; destroy less often
	// so dispatch sometimes frees several tasks.
	task automatic send_random();
		int r;
		logic [2:0] act;
		r = $urandom_range(0, 99);
		if (r < 28) act = ACT_READY;
		else if (r < 36) act = ACT_SUSPEND;
		else if (r < 46) act = ACT_BLOCK;
		else if (r < 55) act = ACT_DESTROY;
		else if (r < 70) act = ACT_SIGNAL;
		else if (r < 96) act = ACT_DISPATCH;
		else act = 3'($urandom_range(6, 7));
		send_action(act, 4'($urandom), 3'($urandom));
	endtask

	// Receiver stalls; one long hold-off once the random part starts.
	initial begin
		m_axis_tready = 1'b0;
		stall_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_go && !stall_taken) begin
				stall_taken = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (150) @(negedge clk);
			end else if ($urandom_range(0, 99) < 25) begin
				m_axis_tready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("priority_fifo_task_scheduler regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		stall_go = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: idle dispatch, every action, extremes, special cases
		send_action(ACT_DISPATCH, 4'd15, 3'd7);
		send_action(ACT_READY, 4'd0, 3'd7);
		send_action(ACT_READY, 4'd15, 3'd0);
		send_action(ACT_READY, 4'd5, 3'd3);
		send_action(ACT_READY, 4'd5, 3'd3);
		send_action(ACT_SIGNAL, 4'd0, 3'd0);
		send_action(ACT_DISPATCH, 4'd0, 3'd0);
		send_action(ACT_DISPATCH, 4'd0, 3'd0);
		send_action(ACT_SIGNAL, 4'd15, 3'd0);
		send_action(ACT_BLOCK, 4'd10, 3'd0);
		send_action(ACT_SIGNAL, 4'd10, 3'd0);
		send_action(ACT_SUSPEND, 4'd15, 3'd0);
		send_action(ACT_SUSPEND, 4'd15, 3'd0);
		send_action(3'd6, 4'd1, 3'd1);
		send_action(3'd7, 4'd15, 3'd7);
		send_action(ACT_DESTROY, 4'd3, 3'd0);
		send_action(ACT_DESTROY, 4'd15, 3'd0);
		send_action(ACT_DESTROY, 4'd3, 3'd0);
		send_action(ACT_DISPATCH, 4'd0, 3'd0);
		send_action(ACT_DISPATCH, 4'd0, 3'd0);
		send_action(ACT_DISPATCH, 4'd0, 3'd0);
		send_action(ACT_DISPATCH, 4'd0, 3'd0);
		for (int i = 0; i < 16; i++) send_action(ACT_DESTROY, 4'(i), 3'd0);
		send_action(ACT_DISPATCH, 4'd0, 3'd0);
		drain();

		// long stall while the sender keeps offering
		stall_go = 1'b1;
		for (int i = 0; i < 230; i++) send_random();
		drain();

		$display("covered %0d results: %0d dispatched, %0d freed, all action codes and stalls",
			n_results, n_dispatched, n_freed);
		if (errors == 0)
			$display("priority_fifo_task_scheduler regression: pass");
		else
			$display("priority_fifo_task_scheduler regression: fail");
		$finish;
	end

endmodule
